// ----- src/bsss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsss_pkg
// Shared widths, register indexes and the job word passed from front to back.
// ----------------------------------------------------------------------------
package bsss_pkg;

    localparam int BASE_W  = 17;
    localparam int RATE_W  = 18;
    localparam int LEN_W   = 18;
    localparam int T_W     = 18;
    localparam int CFG_W   = 18;
    localparam int FT_W    = BASE_W + T_W;     // base * t
    localparam int G_W     = FT_W + T_W;       // base * t * t
    localparam int DEN_W   = RATE_W + LEN_W;   // rate * length
    localparam int LIMIT_W = RATE_W - 1 + LEN_W;
    localparam int PH_W    = 32;               // Q0.32 phase
    localparam int MAG_W   = 31;               // Q1.30 sine magnitude
    localparam int ACC_W   = 34;

    localparam logic [1:0] REG_BASE_FREQ  = 2'd0;
    localparam logic [1:0] REG_SAMPLE_RATE = 2'd1;
    localparam logic [1:0] REG_SWEEP_LEN  = 2'd2;

    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(2050);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);
    localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(88200);

    typedef struct packed {
        logic             zero;   // no harmonics: sample is 0
        logic [FT_W-1:0]  ft;     // first-harmonic frequency term
        logic [DEN_W-1:0] r1;     // g mod den
        logic [DEN_W-1:0] step;   // 2g mod den
    } job_t;

endpackage : bsss_pkg
`default_nettype wire

// ----- src/bsss_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsss_front
// Takes a sample index, forms g = base*t*t and reduces it modulo den.
// ----------------------------------------------------------------------------
module bsss_front (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [bsss_pkg::T_W-1:0]      s_sample_index,
    input  wire  [bsss_pkg::BASE_W-1:0]   base_freq,
    input  wire  [bsss_pkg::DEN_W-1:0]    den,
    output logic                          job_valid,
    input  wire                           job_ready,
    output bsss_pkg::job_t                job
);
    import bsss_pkg::*;

    typedef enum logic [2:0] {F_IDLE, F_MUL_LO, F_MUL_HI, F_MOD, F_STEP, F_PUSH} fstate_t;

    localparam int CNT_W = $clog2(G_W);

    fstate_t           state_reg;
    logic [T_W-1:0]    t_reg;
    logic [FT_W-1:0]   p_reg;
    logic [G_W-1:0]    g_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    job_t              job_reg;

    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_sub;
    logic [DEN_W:0]    dbl;
    logic [G_W-1:0]    hi_prod;

    always_comb begin
        rem_sh  = {rem_reg, g_reg[cnt_reg]};
        rem_sub = rem_sh - {1'b0, den};
        dbl     = {rem_reg, 1'b0};
        hi_prod = G_W'(p_reg[FT_W-1:T_W] * t_reg) << T_W;
    end

    assign s_ready   = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_PUSH);
    assign job       = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        t_reg     <= s_sample_index;
                        p_reg     <= FT_W'(base_freq * s_sample_index);
                        state_reg <= F_MUL_LO;
                    end
                end
                F_MUL_LO: begin
                    g_reg     <= G_W'(p_reg[T_W-1:0] * t_reg);
                    state_reg <= F_MUL_HI;
                end
                F_MUL_HI: begin
                    g_reg       <= g_reg + hi_prod;
                    rem_reg     <= '0;
                    cnt_reg     <= CNT_W'(G_W - 1);
                    job_reg.ft  <= p_reg;
                    if (den == '0) begin
                        job_reg.zero <= 1'b1;
                        job_reg.r1   <= '0;
                        job_reg.step <= '0;
                        state_reg    <= F_PUSH;
                    end else begin
                        job_reg.zero <= 1'b0;
                        state_reg    <= F_MOD;
                    end
                end
                F_MOD: begin
                    // restoring remainder, one bit of g a cycle
                    rem_reg <= rem_sub[DEN_W] ? rem_sh[DEN_W-1:0] : rem_sub[DEN_W-1:0];
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= F_STEP;
                    end
                end
                F_STEP: begin
                    job_reg.r1   <= rem_reg;
                    job_reg.step <= (dbl >= {1'b0, den}) ? DEN_W'(dbl - {1'b0, den})
                                                        : dbl[DEN_W-1:0];
                    state_reg    <= F_PUSH;
                end
                F_PUSH: begin
                    if (job_ready) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule : bsss_front
`default_nettype wire

// ----- src/bsss_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsss_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module bsss_queue (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             in_valid,
    output logic            in_ready,
    input  wire bsss_pkg::job_t in_job,
    output logic            out_valid,
    input  wire             out_ready,
    output bsss_pkg::job_t  out_job
);
    import bsss_pkg::*;

    job_t        slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule : bsss_queue
`default_nettype wire

// ----- src/bsss_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsss_back
// Harmonic loop: phase fraction, quarter-wave sine, divide by h, accumulate,
// then round and saturate into the output register.
// ----------------------------------------------------------------------------
module bsss_back #(
    parameter int MAX_HARMONIC     = 31,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_WIDTH     = 16
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              job_valid,
    output logic                             job_ready,
    input  wire bsss_pkg::job_t              job,
    input  wire  [bsss_pkg::DEN_W-1:0]       den,
    input  wire  [bsss_pkg::LIMIT_W-1:0]     limit,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]   m_audio_sample
);
    import bsss_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_CHECK, B_PHASE, B_ROM, B_HDIV, B_ACC, B_DONE} bstate_t;

    localparam int HW     = $clog2(MAX_HARMONIC + 3);
    localparam int HFT_W  = FT_W + HW;
    localparam int AW     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IDX_PW = 30 + AW;
    localparam int OS     = 32 - SAMPLE_WIDTH;
    localparam int RW     = ACC_W + 1;

    typedef logic [MAG_W-1:0] qtab_t [0:SINE_TABLE_DEPTH];

    function automatic longint unsigned horner_div(input int i);
        case (i)
            0:       horner_div = 64'd110;
            1:       horner_div = 64'd72;
            2:       horner_div = 64'd42;
            3:       horner_div = 64'd20;
            default: horner_div = 64'd6;
        endcase
    endfunction

    // long division by shift and subtract, table build only
    function automatic longint unsigned cdiv(input longint unsigned num,
                                             input longint unsigned dvs);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            q = q << 1;
            if (r >= dvs) begin
                r    = r - dvs;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin(k*pi/2/DEPTH) in Q1.30, Taylor to x^11, pi = 104348/33215
    function automatic qtab_t build_qtab();
        qtab_t             tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   acc;
        longint unsigned   one;
        one = 64'd1 << 30;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x   = cdiv((64'd104348 << 29) * 64'(k), 64'd33215 * 64'(SINE_TABLE_DEPTH));
            x2  = (x * x) >> 30;
            acc = one;
            for (int i = 0; i < 5; i++) begin
                acc = one - cdiv((x2 * acc) >> 30, horner_div(i));
            end
            tab[k] = MAG_W'((x * acc) >> 30);
        end
        return tab;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    bstate_t                  state_reg;
    logic [FT_W-1:0]          ft_reg;
    logic [DEN_W-1:0]         step_reg;
    logic [DEN_W-1:0]         r_reg;
    logic [HFT_W-1:0]         hft_reg;
    logic [HW-1:0]            h_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [DEN_W-1:0]         pr_reg;
    logic [PH_W-1:0]          q_reg;
    logic [3:0]               cnt_reg;
    logic                     neg_reg;
    logic [31:0]              dv_reg;
    logic [HW:0]              hrem_reg;
    logic                     m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] m_sample_reg;

    // two fraction bits a cycle
    logic [DEN_W:0]    pd0, pd1;
    logic [DEN_W-1:0]  pr0, pr1;
    logic              pb0, pb1;
    // four quotient bits a cycle
    logic [HW:0]       hr [0:4];
    logic [3:0]        qb;
    logic [DEN_W:0]    r_next;
    logic [IDX_PW-1:0] idx_prod;
    logic [AW-1:0]     idx;
    logic [AW-1:0]     addr;
    logic signed [RW-1:0] rounded;
    logic signed [RW-1:0] maxv;
    logic signed [RW-1:0] minv;
    logic signed [SAMPLE_WIDTH-1:0] sat;

    always_comb begin
        pd0 = {pr_reg, 1'b0};
        pb0 = (pd0 >= {1'b0, den});
        pr0 = pb0 ? DEN_W'(pd0 - {1'b0, den}) : pd0[DEN_W-1:0];
        pd1 = {pr0, 1'b0};
        pb1 = (pd1 >= {1'b0, den});
        pr1 = pb1 ? DEN_W'(pd1 - {1'b0, den}) : pd1[DEN_W-1:0];

        hr[0] = hrem_reg;
        for (int i = 0; i < 4; i++) begin
            hr[i+1] = {hr[i][HW-1:0], dv_reg[31-i]};
            qb[3-i] = (hr[i+1] >= {1'b0, h_reg});
            if (qb[3-i]) begin
                hr[i+1] = hr[i+1] - {1'b0, h_reg};
            end
        end

        r_next = {1'b0, r_reg} + {1'b0, step_reg};
        if (r_next >= {1'b0, den}) begin
            r_next = r_next - {1'b0, den};
        end

        idx_prod = {{AW{1'b0}}, q_reg[29:0]} * IDX_PW'(SINE_TABLE_DEPTH);
        idx      = idx_prod[IDX_PW-1:30];
        addr     = q_reg[30] ? AW'(SINE_TABLE_DEPTH) - idx : idx;

        maxv    = (RW'(1) <<< (SAMPLE_WIDTH - 1)) - RW'(1);
        minv    = -maxv - RW'(1);
        rounded = (RW'(acc_reg) + (RW'(1) <<< (OS - 1))) >>> OS;
        if (rounded > maxv) begin
            sat = SAMPLE_WIDTH'(maxv);
        end else if (rounded < minv) begin
            sat = SAMPLE_WIDTH'(minv);
        end else begin
            sat = SAMPLE_WIDTH'(rounded);
        end
    end

    assign job_ready      = (state_reg == B_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_audio_sample = m_sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != B_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (job_valid) begin
                        ft_reg    <= job.ft;
                        step_reg  <= job.step;
                        r_reg     <= job.r1;
                        hft_reg   <= HFT_W'(job.ft);
                        h_reg     <= HW'(1);
                        acc_reg   <= '0;
                        state_reg <= job.zero ? B_DONE : B_CHECK;
                    end
                end
                B_CHECK: begin
                    if (h_reg > HW'(MAX_HARMONIC) || hft_reg > HFT_W'(limit)) begin
                        state_reg <= B_DONE;
                    end else begin
                        pr_reg    <= r_reg;
                        cnt_reg   <= '0;
                        state_reg <= B_PHASE;
                    end
                end
                B_PHASE: begin
                    pr_reg  <= pr1;
                    q_reg   <= {q_reg[PH_W-3:0], pb0, pb1};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 4'hF) begin
                        state_reg <= B_ROM;
                    end
                end
                B_ROM: begin
                    dv_reg    <= {1'b0, QTAB[addr]};
                    neg_reg   <= q_reg[31];
                    hrem_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= B_HDIV;
                end
                B_HDIV: begin
                    dv_reg   <= {dv_reg[27:0], qb};
                    hrem_reg <= hr[4];
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == 4'd7) begin
                        state_reg <= B_ACC;
                    end
                end
                B_ACC: begin
                    acc_reg   <= neg_reg ? acc_reg - ACC_W'(dv_reg)
                                         : acc_reg + ACC_W'(dv_reg);
                    h_reg     <= h_reg + HW'(2);
                    hft_reg   <= hft_reg + HFT_W'({ft_reg, 1'b0});
                    r_reg     <= r_next[DEN_W-1:0];
                    state_reg <= B_CHECK;
                end
                B_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_sample_reg <= sat;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule : bsss_back
`default_nettype wire

// ----- src/bandlimited_square_sweep_synth_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bandlimited_square_sweep_synth_unit
// Band-limited square-wave sweep: sums odd harmonics of a linear chirp.
//
//   channel   ports                           word
//   input     s_valid / s_ready               s_sample_index
//   output    m_valid / m_ready               m_audio_sample
//   config    cfg_wr_en / cfg_addr            cfg_wr_data
//
// Front: bit-serial g mod den. Back: per harmonic kept, a check, the phase
// fraction at two bits a cycle, a sine table read, the divide by h and an
// accumulate; up to 16 harmonics at MAX_HARMONIC = 31. A two-word queue lets
// the front take the next word meanwhile.
// Synchronous active-low reset, no clearing pass; results held until taken.
// ----------------------------------------------------------------------------
module bandlimited_square_sweep_synth_unit #(
    parameter int MAX_HARMONIC     = 31,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_WIDTH     = 16
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [bsss_pkg::T_W-1:0]         s_sample_index,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]   m_audio_sample,
    input  wire                              cfg_wr_en,
    input  wire  [1:0]                       cfg_addr,
    input  wire  [bsss_pkg::CFG_W-1:0]       cfg_wr_data
);
    import bsss_pkg::*;

    logic [BASE_W-1:0]  base_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic  fq_valid, fq_ready, qb_valid, qb_ready;
    job_t  fq_job, qb_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
            rate_reg <= RATE_RESET;
            len_reg  <= LEN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BASE_FREQ:   base_reg <= cfg_wr_data[BASE_W-1:0];
                REG_SAMPLE_RATE: rate_reg <= cfg_wr_data[RATE_W-1:0];
                REG_SWEEP_LEN:   len_reg  <= cfg_wr_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // derived products are registered and follow the registers in the next cycle
    always_ff @(posedge aclk) begin
        den_reg   <= DEN_W'(rate_reg * len_reg);
        limit_reg <= LIMIT_W'(rate_reg[RATE_W-1:1] * len_reg);
    end

    bsss_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_index (s_sample_index),
        .base_freq      (base_reg),
        .den            (den_reg),
        .job_valid      (fq_valid),
        .job_ready      (fq_ready),
        .job            (fq_job)
    );

    bsss_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_job   (qb_job)
    );

    bsss_back #(
        .MAX_HARMONIC     (MAX_HARMONIC),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_WIDTH     (SAMPLE_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (qb_valid),
        .job_ready      (qb_ready),
        .job            (qb_job),
        .den            (den_reg),
        .limit          (limit_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_audio_sample (m_audio_sample)
    );

endmodule : bandlimited_square_sweep_synth_unit
`default_nettype wire
